// File: sv/lav_pkg.sv
// Shared types, constants and helper functions of the look-at view matrix core.
// Used by lav_norm and look_at_view_matrix_core; depends on nothing else.
`default_nettype none
package lav_pkg;

  localparam int LAV_IN_W       = 32;
  localparam int LAV_VALUE_W    = 32;
  localparam int LAV_FRAC_BITS  = 16;
  localparam int LAV_NORM_W     = 30;
  localparam int LAV_SQRT_STEPS = 31;
  localparam int LAV_SUM_W      = 62;
  localparam int LAV_LEN_W      = 31;
  localparam int LAV_BEATS      = 12;

  localparam logic LAV_OP_DIR    = 1'b0;
  localparam logic LAV_OP_TARGET = 1'b1;

  typedef struct packed {
    logic                       op;
    logic signed [LAV_IN_W-1:0] pos_x;
    logic signed [LAV_IN_W-1:0] pos_y;
    logic signed [LAV_IN_W-1:0] pos_z;
    logic signed [LAV_IN_W-1:0] dir_x;
    logic signed [LAV_IN_W-1:0] dir_y;
    logic signed [LAV_IN_W-1:0] dir_z;
    logic signed [LAV_IN_W-1:0] up_x;
    logic signed [LAV_IN_W-1:0] up_y;
    logic signed [LAV_IN_W-1:0] up_z;
  } lav_in_t;

  typedef struct packed {
    logic [1:0]                    row;
    logic [1:0]                    col;
    logic signed [LAV_VALUE_W-1:0] value;
    logic                          degenerate;
    logic                          last;
  } lav_out_t;

  typedef struct packed {
    logic valid;
    logic nz;
  } lav_nstat_t;

  function automatic logic signed [LAV_VALUE_W-1:0] lav_sat(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (LAV_VALUE_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) begin
      return hi[LAV_VALUE_W-1:0];
    end else if (x < lo) begin
      return lo[LAV_VALUE_W-1:0];
    end else begin
      return x[LAV_VALUE_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: sv/lav_norm.sv
// Pipelined vector normalizer: power-of-two scaling, sum of squares, bit-serial
// square root stages and restoring division stages, one step per stage. Uses lav_pkg.
`default_nettype none
module lav_norm
  import lav_pkg::*;
#(
  parameter int IN_W      = 33,
  parameter int FRAC_BITS = LAV_FRAC_BITS,
  parameter int SIDE_W    = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [2:0][IN_W-1:0]      in_vec,
  input  logic [SIDE_W-1:0]         in_side,
  output lav_nstat_t                out_stat,
  output logic [2:0][FRAC_BITS+1:0] out_vec,
  output logic [SIDE_W-1:0]         out_side
);

  localparam int GRP = (IN_W + 7) / 8;
  localparam int PW  = $clog2(GRP * 8);
  localparam int MW  = LAV_NORM_W;
  localparam int TGT = LAV_NORM_W - 1;
  localparam int SQ  = LAV_SQRT_STEPS;
  localparam int XW  = LAV_SUM_W;
  localparam int LW  = LAV_LEN_W;
  localparam int RW  = LAV_LEN_W + 1;
  localparam int QB  = FRAC_BITS + 1;
  localparam int NW  = FRAC_BITS + LAV_LEN_W;
  localparam int OW  = FRAC_BITS + 2;

  // Stage 1: magnitudes and signs.
  logic                  v1_r;
  logic [2:0]            sg1_r;
  logic [2:0][IN_W-1:0]  m1_r;
  logic [SIDE_W-1:0]     sd1_r;
  logic [2:0][IN_W-1:0]  m1_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m1_nxt[i] = in_vec[i][IN_W-1] ? IN_W'(-in_vec[i]) : in_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r  <= m1_nxt;
      sd1_r <= in_side;
      for (int i = 0; i < 3; i++) begin
        sg1_r[i] <= in_vec[i][IN_W-1];
      end
    end
  end

  // Stage 2: largest magnitude.
  logic                  v2_r;
  logic [2:0]            sg2_r;
  logic [2:0][IN_W-1:0]  m2_r;
  logic [SIDE_W-1:0]     sd2_r;
  logic [IN_W-1:0]       top2_r;
  logic [IN_W-1:0]       t01;
  logic [IN_W-1:0]       top2_nxt;

  always_comb begin
    t01      = (m1_r[0] > m1_r[1]) ? m1_r[0] : m1_r[1];
    top2_nxt = (t01 > m1_r[2]) ? t01 : m1_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg2_r  <= sg1_r;
      m2_r   <= m1_r;
      sd2_r  <= sd1_r;
      top2_r <= top2_nxt;
    end
  end

  // Stage 3: leading one inside each byte group.
  logic                  v3_r;
  logic [2:0]            sg3_r;
  logic [2:0][IN_W-1:0]  m3_r;
  logic [SIDE_W-1:0]     sd3_r;
  logic [GRP-1:0]        gnz3_r;
  logic [GRP-1:0][2:0]   gmsb3_r;
  logic [GRP*8-1:0]      topx;
  logic [GRP-1:0]        gnz_nxt;
  logic [GRP-1:0][2:0]   gmsb_nxt;

  always_comb begin
    topx = (GRP * 8)'(top2_r);
    for (int g = 0; g < GRP; g++) begin
      gnz_nxt[g]  = |topx[g*8 +: 8];
      gmsb_nxt[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if (topx[g*8+j]) begin
          gmsb_nxt[g] = 3'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg3_r   <= sg2_r;
      m3_r    <= m2_r;
      sd3_r   <= sd2_r;
      gnz3_r  <= gnz_nxt;
      gmsb3_r <= gmsb_nxt;
    end
  end

  // Stage 4: position of the leading one.
  logic                  v4_r;
  logic [2:0]            sg4_r;
  logic [2:0][IN_W-1:0]  m4_r;
  logic [SIDE_W-1:0]     sd4_r;
  logic [PW-1:0]         p4_r;
  logic                  nz4_r;
  logic [PW-1:0]         p4_nxt;

  always_comb begin
    p4_nxt = '0;
    for (int g = 0; g < GRP; g++) begin
      if (gnz3_r[g]) begin
        p4_nxt = PW'(g * 8) + PW'(gmsb3_r[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg4_r <= sg3_r;
      m4_r  <= m3_r;
      sd4_r <= sd3_r;
      p4_r  <= p4_nxt;
      nz4_r <= |gnz3_r;
    end
  end

  // Stage 5: scale so the largest magnitude has its leading one at bit TGT.
  logic                  v5_r;
  logic [2:0]            sg5_r;
  logic [2:0][MW-1:0]    sm5_r;
  logic [SIDE_W-1:0]     sd5_r;
  logic                  nz5_r;
  logic [2:0][MW-1:0]    sm5_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p4_r >= PW'(TGT)) begin
        sm5_nxt[i] = MW'(m4_r[i] >> (p4_r - PW'(TGT)));
      end else begin
        sm5_nxt[i] = MW'(m4_r[i] << (PW'(TGT) - p4_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg5_r <= sg4_r;
      sm5_r <= sm5_nxt;
      sd5_r <= sd4_r;
      nz5_r <= nz4_r;
    end
  end

  // Stage 6: squares.
  logic                   v6_r;
  logic [2:0]             sg6_r;
  logic [2:0][MW-1:0]     sm6_r;
  logic [SIDE_W-1:0]      sd6_r;
  logic                   nz6_r;
  logic [2:0][2*MW-1:0]   sq6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg6_r <= sg5_r;
      sm6_r <= sm5_r;
      sd6_r <= sd5_r;
      nz6_r <= nz5_r;
      for (int i = 0; i < 3; i++) begin
        sq6_r[i] <= sm5_r[i] * sm5_r[i];
      end
    end
  end

  // Square root stages; index 0 is loaded with the sum of squares.
  logic                 qv_r   [0:SQ];
  logic                 qnz_r  [0:SQ];
  logic [2:0]           qsg_r  [0:SQ];
  logic [2:0][MW-1:0]   qm_r   [0:SQ];
  logic [SIDE_W-1:0]    qsd_r  [0:SQ];
  logic [XW-1:0]        qx_r   [0:SQ];
  logic [XW-1:0]        qres_r [0:SQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r[0] <= 1'b0;
    end else if (en) begin
      qv_r[0] <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qnz_r[0]  <= nz6_r;
      qsg_r[0]  <= sg6_r;
      qm_r[0]   <= sm6_r;
      qsd_r[0]  <= sd6_r;
      qx_r[0]   <= XW'(sq6_r[0]) + XW'(sq6_r[1]) + XW'(sq6_r[2]);
      qres_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [XW-1:0] BITV = XW'(1) << (2 * (SQ - 1 - k));
    logic [XW:0]   trial;
    logic          ge;

    assign trial = {1'b0, qres_r[k]} + {1'b0, BITV};
    assign ge    = {1'b0, qx_r[k]} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qv_r[k+1] <= 1'b0;
      end else if (en) begin
        qv_r[k+1] <= qv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qnz_r[k+1]  <= qnz_r[k];
        qsg_r[k+1]  <= qsg_r[k];
        qm_r[k+1]   <= qm_r[k];
        qsd_r[k+1]  <= qsd_r[k];
        qx_r[k+1]   <= ge ? (qx_r[k] - trial[XW-1:0]) : qx_r[k];
        qres_r[k+1] <= ge ? ((qres_r[k] >> 1) + BITV) : (qres_r[k] >> 1);
      end
    end
  end

  // Division stages, one quotient bit per stage and lane.
  logic                 dv_r   [0:QB];
  logic                 dnz_r  [0:QB];
  logic [2:0]           dsg_r  [0:QB];
  logic [SIDE_W-1:0]    dsd_r  [0:QB];
  logic [LW-1:0]        dlen_r [0:QB];
  logic [2:0][NW-1:0]   dnum_r [0:QB];
  logic [2:0][RW-1:0]   drem_r [0:QB];
  logic [2:0][QB-1:0]   dq_r   [0:QB];
  logic [LW-1:0]        len;
  logic [2:0][NW-1:0]   num_nxt;

  assign len = qres_r[SQ][LW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_nxt[i] = (NW'(qm_r[SQ][i]) << FRAC_BITS) + NW'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= qv_r[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dnz_r[0]  <= qnz_r[SQ];
      dsg_r[0]  <= qsg_r[SQ];
      dsd_r[0]  <= qsd_r[SQ];
      dlen_r[0] <= len;
      dnum_r[0] <= num_nxt;
      dq_r[0]   <= '0;
      for (int i = 0; i < 3; i++) begin
        drem_r[0][i] <= RW'(num_nxt[i] >> QB);
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int IDX = QB - 1 - j;
    logic [2:0][RW:0]   t;
    logic [2:0]         ge;
    logic [2:0][RW-1:0] rem_nxt;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]       = {drem_r[j][i], dnum_r[j][i][IDX]};
        ge[i]      = t[i] >= {2'b00, dlen_r[j]};
        rem_nxt[i] = ge[i] ? RW'(t[i] - {2'b00, dlen_r[j]}) : t[i][RW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dnz_r[j+1]  <= dnz_r[j];
        dsg_r[j+1]  <= dsg_r[j];
        dsd_r[j+1]  <= dsd_r[j];
        dlen_r[j+1] <= dlen_r[j];
        dnum_r[j+1] <= dnum_r[j];
        drem_r[j+1] <= rem_nxt;
        for (int i = 0; i < 3; i++) begin
          dq_r[j+1][i] <= {dq_r[j][i][QB-2:0], ge[i]};
        end
      end
    end
  end

  // Output stage: reattach the signs.
  logic               ov_r;
  logic               onz_r;
  logic [2:0][OW-1:0] ovec_r;
  logic [SIDE_W-1:0]  osd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= dv_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      onz_r <= dnz_r[QB];
      osd_r <= dsd_r[QB];
      for (int i = 0; i < 3; i++) begin
        ovec_r[i] <= dsg_r[QB][i] ? (OW'(0) - OW'(dq_r[QB][i])) : OW'(dq_r[QB][i]);
      end
    end
  end

  assign out_stat.valid = ov_r;
  assign out_stat.nz    = onz_r;
  assign out_vec        = ovec_r;
  assign out_side       = osd_r;

endmodule
`default_nettype wire

// File: sv/look_at_view_matrix_core.sv
// Top level of the look-at view matrix core: input register, two normalizers,
// cross products, translation and the twelve-beat result serializer. Uses lav_pkg, lav_norm.
`default_nettype none
// One input beat carries a camera pose; the core answers with the twelve entries
// of rows 0 to 2 of the view matrix, row-major, one result beat each, or with a
// single flagged beat when the direction or up is zero or the two are parallel. The datapath
// is a stalling pipeline that accepts a beat in every cycle in which in_stall is low;
// it stalls while its last stage holds a pose that the result serializer, which drives
// the single-entry output channel, cannot yet take.
module look_at_view_matrix_core
  import lav_pkg::*;
#(
  parameter int FRAC_BITS = LAV_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lav_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output lav_out_t out_data
);

  localparam int IW   = LAV_IN_W;
  localparam int DW   = LAV_IN_W + 1;
  localparam int WW   = FRAC_BITS + 2;
  localparam int PW1  = WW + IW;
  localparam int CW   = FRAC_BITS + 35;
  localparam int VPW  = 2 * WW;
  localparam int VV   = FRAC_BITS + 3;
  localparam int TPW  = VV + IW;
  localparam int TSW  = VV + 35;
  localparam int S2W  = 3 * IW + 3 * WW + 1;
  localparam int CNTW = $clog2(LAV_BEATS);

  localparam logic signed [VPW:0]   VHALF = (VPW + 1)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [TSW-1:0] THALF = TSW'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic [2:0][IW-1:0] pos;
    logic [2:0][WW-1:0] w;
    logic               deg;
  } s2_t;

  logic adv;
  logic can_load;
  logic fv_r;

  assign adv      = !fv_r || can_load;
  assign in_stall = !adv;

  // Stage A: input register and direction.
  logic               av_r;
  logic [2:0][DW-1:0] adir_r;
  logic [2:0][IW-1:0] apos_r;
  logic [2:0][IW-1:0] aup_r;
  logic [2:0][IW-1:0] posv;
  logic [2:0][IW-1:0] dirv;
  logic [2:0][IW-1:0] upv;
  logic [2:0][DW-1:0] adir_nxt;

  assign posv = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
  assign dirv = {in_data.dir_z, in_data.dir_y, in_data.dir_x};
  assign upv  = {in_data.up_z, in_data.up_y, in_data.up_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (in_data.op == LAV_OP_TARGET) begin
        adir_nxt[i] = DW'($signed(dirv[i])) - DW'($signed(posv[i]));
      end else begin
        adir_nxt[i] = DW'($signed(dirv[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r <= 1'b0;
    end else if (adv) begin
      av_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      adir_r <= adir_nxt;
      apos_r <= posv;
      aup_r  <= upv;
    end
  end

  // First normalizer: w.
  lav_nstat_t         n1_stat;
  logic [2:0][WW-1:0] n1_w;
  logic [5:0][IW-1:0] sd1_in;
  logic [5:0][IW-1:0] sd1_out;

  assign sd1_in = {aup_r, apos_r};

  lav_norm #(
    .IN_W      (DW),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (6 * IW)
  ) u_norm_w (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (av_r),
    .in_vec   (adir_r),
    .in_side  (sd1_in),
    .out_stat (n1_stat),
    .out_vec  (n1_w),
    .out_side (sd1_out)
  );

  // Stage C1: cross product terms of w and up.
  logic                   c1v_r;
  logic signed [PW1-1:0]  pc_r [6];
  logic [2:0][IW-1:0]     c1pos_r;
  logic [2:0][WW-1:0]     c1w_r;
  logic                   c1deg_r;
  logic [2:0][IW-1:0]     up1;

  assign up1 = sd1_out[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1v_r <= 1'b0;
    end else if (adv) begin
      c1v_r <= n1_stat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pc_r[0] <= $signed(n1_w[1]) * $signed(up1[2]);
      pc_r[1] <= $signed(n1_w[2]) * $signed(up1[1]);
      pc_r[2] <= $signed(n1_w[2]) * $signed(up1[0]);
      pc_r[3] <= $signed(n1_w[0]) * $signed(up1[2]);
      pc_r[4] <= $signed(n1_w[0]) * $signed(up1[1]);
      pc_r[5] <= $signed(n1_w[1]) * $signed(up1[0]);
      c1pos_r <= sd1_out[2:0];
      c1w_r   <= n1_w;
      c1deg_r <= !n1_stat.nz;
    end
  end

  // Stage C2: cross product.
  logic               c2v_r;
  logic [2:0][CW-1:0] cr_r;
  s2_t                c2sd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2v_r <= 1'b0;
    end else if (adv) begin
      c2v_r <= c1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cr_r[i] <= CW'(pc_r[2*i]) - CW'(pc_r[2*i+1]);
      end
      c2sd_r.pos <= c1pos_r;
      c2sd_r.w   <= c1w_r;
      c2sd_r.deg <= c1deg_r;
    end
  end

  // Second normalizer: u.
  lav_nstat_t         n2_stat;
  logic [2:0][WW-1:0] n2_u;
  s2_t                sd2_out;

  lav_norm #(
    .IN_W      (CW),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (S2W)
  ) u_norm_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (c2v_r),
    .in_vec   (cr_r),
    .in_side  (c2sd_r),
    .out_stat (n2_stat),
    .out_vec  (n2_u),
    .out_side (sd2_out)
  );

  // Stage V1: cross product terms of w and u.
  logic                   v1v_r;
  logic signed [VPW-1:0]  vp_r [6];
  logic [2:0][WW-1:0]     v1u_r;
  logic [2:0][WW-1:0]     v1w_r;
  logic [2:0][IW-1:0]     v1pos_r;
  logic                   v1deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1v_r <= 1'b0;
    end else if (adv) begin
      v1v_r <= n2_stat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vp_r[0] <= $signed(sd2_out.w[1]) * $signed(n2_u[2]);
      vp_r[1] <= $signed(sd2_out.w[2]) * $signed(n2_u[1]);
      vp_r[2] <= $signed(sd2_out.w[2]) * $signed(n2_u[0]);
      vp_r[3] <= $signed(sd2_out.w[0]) * $signed(n2_u[2]);
      vp_r[4] <= $signed(sd2_out.w[0]) * $signed(n2_u[1]);
      vp_r[5] <= $signed(sd2_out.w[1]) * $signed(n2_u[0]);
      v1u_r   <= n2_u;
      v1w_r   <= sd2_out.w;
      v1pos_r <= sd2_out.pos;
      v1deg_r <= sd2_out.deg || !n2_stat.nz;
    end
  end

  // Stage V2: v with rounding; all three axes widened to a common width.
  logic                  v2v_r;
  logic signed [VV-1:0]  ax2_r [3][3];
  logic [2:0][IW-1:0]    v2pos_r;
  logic                  v2deg_r;
  logic signed [VPW:0]   vd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vd[i] = (VPW + 1)'(vp_r[2*i]) - (VPW + 1)'(vp_r[2*i+1]) + VHALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2v_r <= 1'b0;
    end else if (adv) begin
      v2v_r <= v1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ax2_r[0][i] <= VV'($signed(v1u_r[i]));
        ax2_r[1][i] <= VV'(vd[i] >>> FRAC_BITS);
        ax2_r[2][i] <= VV'($signed(v1w_r[i]));
      end
      v2pos_r <= v1pos_r;
      v2deg_r <= v1deg_r;
    end
  end

  // Stage T1: products of the axes with the position.
  logic                  t1v_r;
  logic signed [TPW-1:0] tp_r  [3][3];
  logic signed [VV-1:0]  ax3_r [3][3];
  logic                  t1deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1v_r <= 1'b0;
    end else if (adv) begin
      t1v_r <= v2v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          tp_r[r][i] <= ax2_r[r][i] * $signed(v2pos_r[i]);
        end
      end
      ax3_r   <= ax2_r;
      t1deg_r <= v2deg_r;
    end
  end

  // Stage T2: translation, saturation, finished matrix.
  logic signed [LAV_VALUE_W-1:0] fmat_r [LAV_BEATS];
  logic                          fdeg_r;
  logic signed [TSW-1:0]         ts [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ts[r] = THALF - (TSW'(tp_r[r][0]) + TSW'(tp_r[r][1]) + TSW'(tp_r[r][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (adv) begin
      fv_r <= t1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          fmat_r[r*4+i] <= lav_sat(64'(ax3_r[r][i]));
        end
        fmat_r[r*4+3] <= lav_sat(64'(ts[r] >>> FRAC_BITS));
      end
      fdeg_r <= t1deg_r;
    end
  end

  // Result serializer.
  logic                          ser_v_r;
  logic [CNTW-1:0]               cnt_r;
  logic                          sdeg_r;
  logic signed [LAV_VALUE_W-1:0] sm_r [LAV_BEATS];
  logic                          fire;
  logic                          ser_end;

  assign fire     = ser_v_r && !out_stall;
  assign ser_end  = sdeg_r || (cnt_r == CNTW'(LAV_BEATS - 1));
  assign can_load = !ser_v_r || (fire && ser_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      cnt_r   <= '0;
    end else if (can_load) begin
      ser_v_r <= fv_r;
      cnt_r   <= '0;
    end else if (fire) begin
      cnt_r <= cnt_r + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      sm_r   <= fmat_r;
      sdeg_r <= fdeg_r;
    end else if (fire) begin
      for (int k = 0; k < LAV_BEATS - 1; k++) begin
        sm_r[k] <= sm_r[k+1];
      end
    end
  end

  assign out_valid           = ser_v_r;
  assign out_data.row        = cnt_r[3:2];
  assign out_data.col        = cnt_r[1:0];
  assign out_data.value      = sdeg_r ? '0 : sm_r[0];
  assign out_data.degenerate = sdeg_r;
  assign out_data.last       = ser_end;

`ifndef SYNTHESIS
  a_deg_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.last && cnt_r == '0)
    else $error("flagged result is not a single beat");

  a_row_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.row != 2'd3)
    else $error("result row out of range");

  a_mid_matrix : assert property (@(posedge clk) disable iff (!rst_n)
    fire && !ser_end |=> ser_v_r && cnt_r == $past(cnt_r) + CNTW'(1))
    else $error("matrix beat sequence broken");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    fv_r && !can_load |-> in_stall)
    else $error("pipeline advanced while the serializer was busy");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    ser_v_r && out_stall |=> $stable(cnt_r) && ser_v_r)
    else $error("serializer moved under a stalled beat");
`endif

endmodule
`default_nettype wire
